[hw/rtl/gqla_pkg.sv]
// Shared types, widths and codes for the glyph quad layout block.
// Used by gqla_quad and glyph_quad_layout; no dependencies of its own.
`timescale 1ns / 1ps

package gqla_pkg;

  localparam int CODE_COUNT_DEF  = 65536;
  localparam int GLYPH_COUNT_DEF = 4096;
  localparam int GLYPH_IDX_W     = 12;
  localparam int MAP_W           = GLYPH_IDX_W + 1;
  localparam int GLYPH_W         = 56;

  localparam int IN_TDATA_W  = 136;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 192;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Largest advance: ((2^25 - 1) * (2^16 - 1)) >> 12 fits in 29 bits.
  localparam int ADV_W = 29;

  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_GLYPH = 2'd1;
  localparam logic [1:0] OP_PEN   = 2'd2;
  localparam logic [1:0] OP_PLACE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MONOSPACE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RCP_W     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RCP_H     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR     = 3'd6;

  localparam logic [15:0] LOW_CODE_MAX = 16'h00ff;

  typedef struct packed {
    logic [7:0]  off;
    logic [7:0]  h;
    logic [7:0]  w;
    logic [15:0] v;
    logic [15:0] u;
  } glyph_rec_t;

  typedef struct packed {
    logic [23:0] scale;
    logic [15:0] spacing;
    logic        monospace;
    logic [7:0]  font_size;
    logic [23:0] rcp_w;
    logic [23:0] rcp_h;
    logic [31:0] color;
  } cfg_t;

  typedef struct packed {
    logic [23:0] sw;
    logic [23:0] sh;
    logic [23:0] so;
    logic [15:0] tu;
    logic [15:0] tv;
    logic [15:0] tw;
    logic [15:0] th;
  } quad_prod_t;

  // Texel count times a Q0.24 reciprocal, brought to Q0.16 and clamped.
  function automatic logic [15:0] tex_sat(input logic [39:0] p);
    logic [15:0] r;
    if (p[39:24] != 16'd0) begin
      r = 16'hffff;
    end else begin
      r = p[23:8];
    end
    return r;
  endfunction

endpackage

[hw/rtl/gqla_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the code map and the glyph store.
`timescale 1ns / 1ps

module gqla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/gqla_quad.sv]
// Glyph scaling stage: quad size, bearing and atlas coordinates of one glyph.
// Depends on gqla_pkg for the glyph record, configuration and result types.
`timescale 1ns / 1ps

module gqla_quad (
  input  logic                clk,
  input  logic                load,
  input  gqla_pkg::glyph_rec_t glyph,
  input  gqla_pkg::cfg_t      cfg,
  output gqla_pkg::quad_prod_t prod
);

  import gqla_pkg::*;

  logic [31:0] w_prod;
  logic [31:0] h_prod;
  logic [31:0] o_prod;
  logic [39:0] u_prod;
  logic [39:0] v_prod;
  logic [39:0] tw_prod;
  logic [39:0] th_prod;

  // Each product is a single multiplier feeding the result register.
  assign w_prod  = 32'(glyph.w) * 32'(cfg.scale);
  assign h_prod  = 32'(glyph.h) * 32'(cfg.scale);
  assign o_prod  = 32'(glyph.off) * 32'(cfg.scale);
  assign u_prod  = 40'(glyph.u) * 40'(cfg.rcp_w);
  assign v_prod  = 40'(glyph.v) * 40'(cfg.rcp_h);
  assign tw_prod = 40'(glyph.w) * 40'(cfg.rcp_w);
  assign th_prod = 40'(glyph.h) * 40'(cfg.rcp_h);

  // An 8-bit texel count times a 24-bit scale never exceeds 24 bits after the shift.
  always_ff @(posedge clk) begin
    if (load) begin
      prod.sw <= w_prod[31:8];
      prod.sh <= h_prod[31:8];
      prod.so <= o_prod[31:8];
      prod.tu <= tex_sat(u_prod);
      prod.tv <= tex_sat(v_prod);
      prod.tw <= tex_sat(tw_prod);
      prod.th <= tex_sat(th_prod);
    end
  end

endmodule

[hw/rtl/glyph_quad_layout.sv]
// Top level of the glyph quad layout block: sequencer, pen and registers.
// Depends on gqla_pkg, gqla_ram and gqla_quad.
`timescale 1ns / 1ps

// Usage:
// Input transactions arrive on the s_ group; s_tuser selects the operation:
// load a code map entry, load a glyph record, set the pen, or place a char.
// Each placed character with a present glyph yields one quad transaction on
// the m_ group; every other transaction yields nothing.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Map, glyph and pen writes complete at the accepting edge. For a placed
// character the code map is read at the accepting edge; the dependent glyph
// store read, the scaling multipliers and the advance multiplier follow in
// turn; the final state then loads the output register and updates the pen,
// but a character with a quad waits there while an earlier quad is held. The
// input is held off until then, so the block takes no new character before
// the last one is through.
// The output register holds a finished quad while the receiver stalls, and
// the next transaction is accepted meanwhile; only a following quad waits.
// Reset clears the pen, restores the register defaults and empties the
// output. Both memories come up undefined, and the user must write an entry
// before it is used; the block does not enforce this and has no clearing pass.

module glyph_quad_layout #(
  parameter int CODE_COUNT  = gqla_pkg::CODE_COUNT_DEF,
  parameter int GLYPH_COUNT = gqla_pkg::GLYPH_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // code[15:0], glyph_index[27:16], glyph_present[28], atlas_u[44:29],
  // atlas_v[60:45], glyph_width[68:61], glyph_height[76:69],
  // glyph_offset[84:77], start_x[108:85], start_y[132:109], zero fill
  input  logic [gqla_pkg::IN_TDATA_W-1:0]  s_tdata,
  // op[1:0]
  input  logic [gqla_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // quad_x[23:0], quad_y[47:24], quad_w[71:48], quad_h[95:72],
  // tex_u[111:96], tex_v[127:112], tex_w[143:128], tex_h[159:144],
  // quad_color[191:160]
  output logic [gqla_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_we,
  input  logic [gqla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gqla_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import gqla_pkg::*;

  localparam int CODE_AW     = $clog2(CODE_COUNT);
  localparam int GLYPH_DEPTH = (GLYPH_COUNT > (1 << GLYPH_IDX_W)) ?
                               (1 << GLYPH_IDX_W) : GLYPH_COUNT;
  localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
  localparam logic [16:0] CODE_LIMIT  = 17'(CODE_COUNT);
  localparam logic [16:0] GLYPH_LIMIT = 17'(GLYPH_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAP  = 3'd1;
  localparam logic [2:0] ST_GLY  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic signed [30:0] PEN_MAX = 31'sd8388607;
  localparam logic signed [30:0] PEN_MIN = -31'sd8388608;
  localparam logic signed [25:0] QX_MAX  = 26'sd8388607;

  // Input fields.
  logic [1:0]               in_op;
  logic [15:0]              in_code;
  logic [GLYPH_IDX_W-1:0]   in_gidx;
  logic                     in_present;
  glyph_rec_t               in_glyph;
  logic signed [23:0]       in_start_x;
  logic signed [23:0]       in_start_y;

  assign in_op          = s_tuser[1:0];
  assign in_code        = s_tdata[15:0];
  assign in_gidx        = s_tdata[27:16];
  assign in_present     = s_tdata[28];
  assign in_glyph.u     = s_tdata[44:29];
  assign in_glyph.v     = s_tdata[60:45];
  assign in_glyph.w     = s_tdata[68:61];
  assign in_glyph.h     = s_tdata[76:69];
  assign in_glyph.off   = s_tdata[84:77];
  assign in_start_x     = s_tdata[108:85];
  assign in_start_y     = s_tdata[132:109];

  logic [2:0]         state;
  cfg_t               cfg;
  logic signed [23:0] pen_x;
  logic signed [23:0] pen_y;

  logic               code_ok;
  logic               code_ok_q;
  logic               low_q;
  logic               present_q;
  logic [31:0]        bs_scale_q;
  logic [ADV_W-1:0]   fixed_q;
  logic [ADV_W-1:0]   adv_q;
  logic signed [23:0] qx_q;

  logic               accept;
  logic               map_we;
  logic               glyph_we;
  logic [MAP_W-1:0]   map_rdata;
  logic [GLYPH_W-1:0] glyph_rdata;
  logic               map_present;
  quad_prod_t         prod;
  logic               fin_stall;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign code_ok  = ({1'b0, in_code} < CODE_LIMIT);
  assign map_we   = accept && (in_op == OP_MAP) && code_ok;
  assign glyph_we = accept && (in_op == OP_GLYPH) &&
                    ({5'd0, in_gidx} < GLYPH_LIMIT);

  // All memory writes happen on acceptance in idle, and a placement's reads
  // start at its own acceptance, so no placement reads an entry being written.
  gqla_ram #(
    .WIDTH (MAP_W),
    .DEPTH (CODE_COUNT)
  ) u_code_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (in_code[CODE_AW-1:0]),
    .wdata ({in_present, in_gidx}),
    .raddr (in_code[CODE_AW-1:0]),
    .rdata (map_rdata)
  );

  gqla_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (GLYPH_DEPTH)
  ) u_glyph_store (
    .clk   (clk),
    .we    (glyph_we),
    .waddr (in_gidx[GLYPH_AW-1:0]),
    .wdata (in_glyph),
    .raddr (map_rdata[GLYPH_AW-1:0]),
    .rdata (glyph_rdata)
  );

  assign map_present = map_rdata[MAP_W-1] && code_ok_q &&
                       ({5'd0, map_rdata[GLYPH_IDX_W-1:0]} < GLYPH_LIMIT);

  gqla_quad u_quad (
    .clk   (clk),
    .load  (state == ST_GLY),
    .glyph (glyph_rec_t'(glyph_rdata)),
    .cfg   (cfg),
    .prod  (prod)
  );

  // Advance and placement arithmetic.
  logic [47:0]        fix_prod;
  logic [40:0]        prop_prod;
  logic signed [25:0] qx_sum;
  logic signed [30:0] pen_sum;
  logic signed [23:0] pen_next;

  assign fix_prod  = 48'(bs_scale_q) * 48'(cfg.spacing);
  assign prop_prod = 41'({1'b0, prod.sw} + {1'b0, prod.so}) * 41'(cfg.spacing);
  assign qx_sum    = 26'(pen_x) + $signed({2'b00, prod.so});
  assign pen_sum   = 31'(pen_x) + $signed({2'b00, adv_q});

  always_comb begin
    if (pen_sum > PEN_MAX) begin
      pen_next = 24'(PEN_MAX);
    end else if (pen_sum < PEN_MIN) begin
      pen_next = 24'(PEN_MIN);
    end else begin
      pen_next = pen_sum[23:0];
    end
  end

  assign fin_stall = present_q && m_tvalid && !m_tready;

  // Control state, pen and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pen_x         <= '0;
      pen_y         <= '0;
      m_tvalid      <= 1'b0;
      cfg.scale     <= 24'd65536;
      cfg.spacing   <= 16'd4096;
      cfg.monospace <= 1'b0;
      cfg.font_size <= 8'd16;
      cfg.rcp_w     <= 24'd16384;
      cfg.rcp_h     <= 24'd16384;
      cfg.color     <= 32'hffffffff;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE:     cfg.scale     <= cfg_data[23:0];
          REG_SPACING:   cfg.spacing   <= cfg_data[15:0];
          REG_MONOSPACE: cfg.monospace <= cfg_data[0];
          REG_FONT_SIZE: cfg.font_size <= cfg_data[7:0];
          REG_RCP_W:     cfg.rcp_w     <= cfg_data[23:0];
          REG_RCP_H:     cfg.rcp_h     <= cfg_data[23:0];
          REG_COLOR:     cfg.color     <= cfg_data;
          default: ;
        endcase
      end

      // A new quad may replace one that leaves in the same cycle.
      if (state == ST_FIN && present_q && !fin_stall) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_op == OP_PEN) begin
              pen_x <= in_start_x;
              pen_y <= in_start_y;
            end
            if (in_op == OP_PLACE) begin
              state <= ST_MAP;
            end
          end
        end
        ST_MAP: state <= ST_GLY;
        ST_GLY: state <= ST_MUL;
        ST_MUL: state <= ST_FIN;
        ST_FIN: begin
          if (!fin_stall) begin
            pen_x <= pen_next;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      code_ok_q <= code_ok;
      low_q     <= (in_code <= LOW_CODE_MAX);
    end
    if (state == ST_MAP) begin
      present_q  <= map_present;
      bs_scale_q <= 32'(cfg.font_size) * 32'(cfg.scale);
    end
    if (state == ST_GLY) begin
      if (low_q) begin
        fixed_q <= ADV_W'(fix_prod >> 21);
      end else begin
        fixed_q <= ADV_W'(fix_prod >> 20);
      end
    end
    if (state == ST_MUL) begin
      if (cfg.monospace || !present_q) begin
        adv_q <= fixed_q;
      end else begin
        adv_q <= ADV_W'(prop_prod >> 12);
      end
      // The bearing is never negative, so only the upper bound can be hit.
      if (qx_sum > QX_MAX) begin
        qx_q <= 24'(QX_MAX);
      end else begin
        qx_q <= qx_sum[23:0];
      end
    end
    if (state == ST_FIN && present_q && !fin_stall) begin
      m_tdata <= {cfg.color, prod.th, prod.tw, prod.tv, prod.tu,
                  prod.sh, prod.sw, pen_y, qx_q};
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for glyph_quad_layout: stream stimulus, config writes
// and a quad predictor with an in-order checker. Depends on gqla_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import gqla_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 160;
  localparam int PRESSURE_ITEMS = 40;

  typedef struct packed {
    logic [2:0]  pad;
    logic [23:0] start_y;
    logic [23:0] start_x;
    logic [7:0]  off;
    logic [7:0]  h;
    logic [7:0]  w;
    logic [15:0] v;
    logic [15:0] u;
    logic        present;
    logic [11:0] gidx;
    logic [15:0] code;
  } in_item_t;

  typedef struct packed {
    logic [31:0] quad_color;
    logic [15:0] tex_h;
    logic [15:0] tex_w;
    logic [15:0] tex_v;
    logic [15:0] tex_u;
    logic [23:0] quad_h;
    logic [23:0] quad_w;
    logic [23:0] quad_y;
    logic [23:0] quad_x;
  } quad_t;

  class quad_tracker;
    logic [MAP_W-1:0] code_map [int];
    glyph_rec_t       glyphs [int];
    longint           pen_x;
    longint           pen_y;
    cfg_t             regs;
    quad_t            pending_quads [$];
    int               mismatches;

    function new();
      pen_x = 0;
      pen_y = 0;
      regs.scale     = 24'd65536;
      regs.spacing   = 16'd4096;
      regs.monospace = 1'b0;
      regs.font_size = 8'd16;
      regs.rcp_w     = 24'd16384;
      regs.rcp_h     = 24'd16384;
      regs.color     = 32'hffffffff;
      mismatches = 0;
    endfunction

    function longint clamp24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function logic [15:0] tex_norm(longint unsigned texels, longint unsigned rcp);
      longint unsigned p;
      p = (texels * rcp) >> 8;
      return (p > 64'hffff) ? 16'hffff : 16'(p);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_SCALE:     regs.scale = val[23:0];
        REG_SPACING:   regs.spacing = val[15:0];
        REG_MONOSPACE: regs.monospace = val[0];
        REG_FONT_SIZE: regs.font_size = val[7:0];
        REG_RCP_W:     regs.rcp_w = val[23:0];
        REG_RCP_H:     regs.rcp_h = val[23:0];
        REG_COLOR:     regs.color = val;
        default: ;
      endcase
    endfunction

    function void note_item(logic [1:0] op, in_item_t it);
      logic [MAP_W-1:0] entry;
      glyph_rec_t g;
      quad_t q;
      longint unsigned sc, sp, bs, adv, sw, sh, so;
      sc = regs.scale;
      sp = regs.spacing;
      bs = regs.font_size;
      case (op)
        OP_MAP: code_map[it.code] = {it.present, it.gidx};
        OP_GLYPH: glyphs[it.gidx] = '{off: it.off, h: it.h, w: it.w, v: it.v, u: it.u};
        OP_PEN: begin
          pen_x = longint'($signed(it.start_x));
          pen_y = longint'($signed(it.start_y));
        end
        default: begin
          // Low codes take the half advance, all others the full one.
          adv = (bs * sc * sp) >> ((it.code <= LOW_CODE_MAX) ? 21 : 20);
          entry = code_map.exists(it.code) ? code_map[it.code] : '0;
          if (entry[MAP_W-1]) begin
            g = glyphs.exists(entry[GLYPH_IDX_W-1:0]) ? glyphs[entry[GLYPH_IDX_W-1:0]] : '0;
            sw = (g.w * sc) >> 8;
            sh = (g.h * sc) >> 8;
            so = (g.off * sc) >> 8;
            q.quad_x = 24'(clamp24(pen_x + longint'(so)));
            q.quad_y = 24'(pen_y);
            q.quad_w = 24'(sw);
            q.quad_h = 24'(sh);
            q.tex_u = tex_norm(g.u, regs.rcp_w);
            q.tex_v = tex_norm(g.v, regs.rcp_h);
            q.tex_w = tex_norm(g.w, regs.rcp_w);
            q.tex_h = tex_norm(g.h, regs.rcp_h);
            q.quad_color = regs.color;
            pending_quads.insert(pending_quads.size(), q);
            if (!regs.monospace) adv = ((sw + so) * sp) >> 12;
          end
          pen_x = clamp24(pen_x + longint'(adv));
        end
      endcase
    endfunction

    function void compare_field(string field_name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %h, got %h", $time, field_name, want, got);
      end
    endfunction

    function void check_quad(quad_t got);
      quad_t want;
      if (pending_quads.size() == 0) begin
        mismatches++;
        $display("%0t: quad expected none, got %h", $time, got);
        return;
      end
      want = pending_quads.pop_front();
      compare_field("quad_x", 32'(want.quad_x), 32'(got.quad_x));
      compare_field("quad_y", 32'(want.quad_y), 32'(got.quad_y));
      compare_field("quad_w", 32'(want.quad_w), 32'(got.quad_w));
      compare_field("quad_h", 32'(want.quad_h), 32'(got.quad_h));
      compare_field("tex_u", 32'(want.tex_u), 32'(got.tex_u));
      compare_field("tex_v", 32'(want.tex_v), 32'(got.tex_v));
      compare_field("tex_w", 32'(want.tex_w), 32'(got.tex_w));
      compare_field("tex_h", 32'(want.tex_h), 32'(got.tex_h));
      compare_field("quad_color", want.quad_color, got.quad_color);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  quad_tracker sb = new();
  logic [15:0] mapped_codes [$];
  logic [11:0] loaded_glyphs [$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int quiet_cycles = 0;

  glyph_quad_layout dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_quad(m_tdata);
      if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic in_item_t random_fields();
    in_item_t it;
    it.pad = '0;
    it.code = 16'($urandom);
    it.gidx = 12'($urandom);
    it.present = 1'($urandom);
    it.u = 16'($urandom);
    it.v = 16'($urandom);
    it.w = 8'($urandom);
    it.h = 8'($urandom);
    it.off = 8'($urandom);
    it.start_x = 24'($urandom);
    it.start_y = 24'($urandom);
    return it;
  endfunction

  task automatic send(logic [1:0] op, in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= it;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic put_map(logic [15:0] code, logic [11:0] gidx, logic present);
    in_item_t it;
    it = random_fields();
    it.code = code;
    it.gidx = gidx;
    it.present = present;
    mapped_codes.insert(mapped_codes.size(), code);
    send(OP_MAP, it);
  endtask

  task automatic put_glyph(logic [11:0] gidx, logic [15:0] u, logic [15:0] v,
                           logic [7:0] w, logic [7:0] h, logic [7:0] off);
    in_item_t it;
    it = random_fields();
    it.gidx = gidx;
    it.u = u;
    it.v = v;
    it.w = w;
    it.h = h;
    it.off = off;
    loaded_glyphs.insert(loaded_glyphs.size(), gidx);
    send(OP_GLYPH, it);
  endtask

  task automatic put_pen(logic [23:0] x, logic [23:0] y);
    in_item_t it;
    it = random_fields();
    it.start_x = x;
    it.start_y = y;
    send(OP_PEN, it);
  endtask

  task automatic place(logic [15:0] code);
    in_item_t it;
    it = random_fields();
    it.code = code;
    send(OP_PLACE, it);
  endtask

  function automatic logic [15:0] some_mapped_code();
    return mapped_codes[$urandom_range(mapped_codes.size() - 1)];
  endfunction

  // Mostly placements of mapped codes, mixed with table loads and pen moves.
  // Map entries always point at loaded glyph records, even when marked absent.
  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 72) begin
      place(some_mapped_code());
    end else if (pick < 82) begin
      put_glyph(12'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
    end else if (pick < 92) begin
      put_map(($urandom_range(9) < 3) ? 16'($urandom_range(255)) : 16'($urandom),
              loaded_glyphs[$urandom_range(loaded_glyphs.size() - 1)],
              $urandom_range(9) < 8);
    end else begin
      put_pen(24'($urandom), 24'($urandom));
    end
  endtask

  // The pause after the last quad covers placements of absent glyphs still in flight.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_quads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_settings(cfg_t c);
    put_reg(REG_SCALE, 32'(c.scale));
    put_reg(REG_SPACING, 32'(c.spacing));
    put_reg(REG_MONOSPACE, 32'(c.monospace));
    put_reg(REG_FONT_SIZE, 32'(c.font_size));
    put_reg(REG_RCP_W, 32'(c.rcp_w));
    put_reg(REG_RCP_H, 32'(c.rcp_h));
    put_reg(REG_COLOR, c.color);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t phase_settings(int p);
    cfg_t c;
    c.color = $urandom;
    c.monospace = 1'($urandom);
    c.font_size = 8'($urandom);
    c.rcp_w = 24'($urandom_range(24'h00ffff));
    c.rcp_h = 24'($urandom_range(24'h00ffff));
    c.scale = 24'($urandom_range(24'h03ffff));
    c.spacing = 16'($urandom_range(16'h3fff));
    case (p)
      0, 4: begin
        c.scale = 24'hffffff;
        c.spacing = 16'hffff;
        c.monospace = (p == 4);
        c.font_size = 8'hff;
        c.rcp_w = 24'hffffff;
        c.rcp_h = 24'hffffff;
        if (p == 0) c.color = 32'hffffffff;
      end
      1: c = '0;
      2: begin
        c.scale = 24'h010000;
        c.spacing = 16'h1000;
        c.monospace = 1'b1;
        c.font_size = 8'd16;
        c.rcp_w = 24'd16384;
        c.rcp_h = 24'd16384;
      end
      3: begin
        c.scale = 24'($urandom);
        c.spacing = 16'($urandom);
        c.rcp_w = 24'($urandom);
        c.rcp_h = 24'($urandom);
      end
      5: c.font_size = 8'd1;
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= '0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings: field extremes, low and high codes,
    // absent glyphs, pen saturation and back-to-back dependent writes.
    put_glyph(12'h000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);
    put_glyph(12'hfff, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff);
    put_glyph(12'h5a5, 16'h1234, 16'h0abc, 8'd9, 8'd14, 8'd2);
    put_map(16'h0041, 12'h5a5, 1'b1);
    put_map(16'hffff, 12'hfff, 1'b1);
    put_map(16'h0000, 12'h000, 1'b1);
    put_map(16'h00ff, 12'h000, 1'b0);
    put_map(16'h0100, 12'hfff, 1'b0);
    put_pen(24'h000000, 24'h000000);
    place(16'h0041);
    place(16'hffff);
    place(16'h0000);
    place(16'h00ff);
    place(16'h0100);
    put_pen(24'h7fffff, 24'h7fffff);
    place(16'hffff);
    place(16'h0041);
    put_pen(24'h800000, 24'h800000);
    place(16'h0100);
    place(16'h0041);
    put_map(16'h1234, 12'h5a5, 1'b1);
    place(16'h1234);
    put_glyph(12'h5a5, 16'h0001, 16'hfffe, 8'h80, 8'h01, 8'h7f);
    place(16'h0041);

    for (int p = 0; p < 8; p++) begin
      drain();
      load_settings(phase_settings(p));
      send_idle_pct = (p % 4 == 1) ? 72 : (p % 4 == 3) ? 35 : 0;
      stall_pct     = (p % 4 == 2) ? 72 : (p % 4 == 3) ? 35 : 0;
      repeat (PHASE_ITEMS) random_item();
      if (p == 0) begin
        // Long receiver hold-off while placements keep coming, so the block backs up.
        hold_request = HOLD_CYCLES;
        repeat (PRESSURE_ITEMS) place(some_mapped_code());
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_quads.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
